FILE: rtl/ggep_pkg.sv
// shared types, codes and constants for the ggep extension area parser
package ggep_pkg;

    // framing constants
    localparam logic [7:0] MAGIC_BYTE  = 8'hC3;
    localparam logic [1:0] TAG_MORE    = 2'b10;
    localparam logic [1:0] TAG_LAST    = 2'b01;
    localparam logic [2:0] MIN_PACKET  = 3'd5;
    localparam int         LEN_W       = 18;
    localparam int         LEN_GROUP_W = 6;

    // parser phase codes
    localparam logic [2:0] PH_MAGIC   = 3'd0;
    localparam logic [2:0] PH_FLAGS   = 3'd1;
    localparam logic [2:0] PH_ID      = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_AFTER   = 3'd5;

    // status codes
    localparam logic [3:0] ST_RUN    = 4'd0;
    localparam logic [3:0] ST_OK     = 4'd1;
    localparam logic [3:0] ST_MAGIC  = 4'd2;
    localparam logic [3:0] ST_SHORT  = 4'd3;
    localparam logic [3:0] ST_IDZERO = 4'd4;
    localparam logic [3:0] ST_IDNUL  = 4'd5;
    localparam logic [3:0] ST_TAG    = 4'd6;
    localparam logic [3:0] ST_UNTERM = 4'd7;
    localparam logic [3:0] ST_TRUNC  = 4'd8;

    // byte role codes
    localparam logic [2:0] ROLE_IGNORED = 3'd0;
    localparam logic [2:0] ROLE_MAGIC   = 3'd1;
    localparam logic [2:0] ROLE_FLAGS   = 3'd2;
    localparam logic [2:0] ROLE_ID      = 3'd3;
    localparam logic [2:0] ROLE_LEN     = 3'd4;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd5;

    // output beat widths
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 3;

    typedef struct packed {
        logic [2:0]       phase;
        logic [2:0]       bytes_seen;
        logic [7:0]       flags;
        logic [3:0]       id_left;
        logic [1:0]       len_read;
        logic [LEN_W-1:0] len_acc;
        logic [LEN_W-1:0] pay_left;
        logic [7:0]       block_cnt;
        logic [3:0]       verdict;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:      PH_MAGIC,
        bytes_seen: 3'd0,
        flags:      8'd0,
        id_left:    4'd0,
        len_read:   2'd0,
        len_acc:    '0,
        pay_left:   '0,
        block_cnt:  8'd0,
        verdict:    ST_RUN
    };

    typedef struct packed {
        logic [2:0]       byte_role;
        logic [7:0]       echo_byte;
        logic [7:0]       block_number;
        logic [7:0]       block_flags;
        logic [3:0]       id_length;
        logic [LEN_W-1:0] payload_length;
        logic             header_done;
        logic             payload_done;
        logic [3:0]       status;
    } t_result;

endpackage

FILE: rtl/ggep_block_parser_top.sv
// top level of the ggep extension area parser with output skid stage
//
// channel  | dir | fields
// ---------+-----+---------------------------------------------------------
// s (in)   | in  | tdata: data_byte; tlast: packet_end
// m (out)  | out | tdata: result fields; tuser: byte_role
//
// one input beat gives one output beat; a beat may be taken every cycle
// the whole step is a single cycle of logic from the parse state register
// to the output register, so throughput is one byte per clock
// a skid register behind the output keeps the input open for one more beat
// while the output stalls; the input drops ready only when both are full
// synchronous active-low reset clears parse state and both valid flags
module ggep_block_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // packet_end
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [ggep_pkg::OUT_TDATA_W-1:0] o_m_tdata,
                                     // [7:0] echo_byte, [15:8] block_number,
                                     // [23:16] block_flags, [27:24] id_length,
                                     // [45:28] payload_length, [46] header_done,
                                     // [47] payload_done, [51:48] status, rest zero
    output logic [ggep_pkg::OUT_TUSER_W-1:0] o_m_tuser  // [2:0] byte_role
);

    ggep_pkg::t_state  r_state;
    ggep_pkg::t_state  n_state;
    ggep_pkg::t_result w_result;
    ggep_pkg::t_result r_out;
    ggep_pkg::t_result r_skid;
    logic              r_out_valid;
    logic              r_skid_valid;
    logic              w_accept;
    logic              w_pop;

    // parse step for the beat on the input
    ggep_step u_step (
        .i_state  (r_state),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_state  (n_state),
        .o_result (w_result)
    );

    assign o_s_tready = !r_skid_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_pop      = r_out_valid && i_m_tready;

    // parse state advances on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ggep_pkg::STATE_RESET;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // output register plus skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                // skid drains first, input is closed this cycle
                r_skid_valid <= 1'b0;
            end else if (!w_accept) begin
                r_out_valid <= 1'b0;
            end
        end else if (w_accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // payload moves without reset
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_result;
            end
        end else if (w_accept) begin
            if (r_out_valid) begin
                r_skid <= w_result;
            end else begin
                r_out <= w_result;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.byte_role;
    assign o_m_tdata  = {4'd0, r_out.status, r_out.payload_done, r_out.header_done,
                         r_out.payload_length, r_out.id_length, r_out.block_flags,
                         r_out.block_number, r_out.echo_byte};

    // skid never holds a beat unless the output register does too
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid valid without output valid");

    // a beat taken while the output stalls must land in the skid
    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_out_valid && !i_m_tready) |=> r_skid_valid)
        else $error("beat lost on output stall");

    // the last beat of a packet returns the parser to its start
    a_packet_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_tlast) |=>
            (r_state.phase == ggep_pkg::PH_MAGIC && r_state.bytes_seen == 3'd0 &&
             r_state.verdict == ggep_pkg::ST_RUN))
        else $error("parser not cleared after packet end");

    // byte count saturates at the minimum packet size
    a_bytes_seen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_seen <= ggep_pkg::MIN_PACKET)
        else $error("byte count beyond saturation");

endmodule

FILE: rtl/ggep_step.sv
// one byte of parser work: next state and result beat from current state
module ggep_step (
    input  ggep_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output ggep_pkg::t_state  o_state,
    output ggep_pkg::t_result o_result
);

    ggep_pkg::t_state s;
    logic [2:0]       role;
    logic             hdr;
    logic             pdone;
    logic [3:0]       status;
    logic [2:0]       end_phase;

    // phase once a block is over
    assign end_phase = i_state.flags[7] ? ggep_pkg::PH_AFTER : ggep_pkg::PH_FLAGS;

    always_comb begin
        s     = i_state;
        role  = ggep_pkg::ROLE_IGNORED;
        hdr   = 1'b0;
        pdone = 1'b0;
        if (i_state.verdict == ggep_pkg::ST_RUN) begin
            case (i_state.phase)
                ggep_pkg::PH_FLAGS: begin
                    role = ggep_pkg::ROLE_FLAGS;
                    if (i_state.bytes_seen != 3'd1 && i_state.block_cnt != 8'hFF) begin
                        s.block_cnt = i_state.block_cnt + 8'd1;
                    end
                    s.flags    = i_byte;
                    s.len_acc  = '0;
                    s.pay_left = '0;
                    s.len_read = 2'd0;
                    s.id_left  = i_byte[3:0];
                    if (i_byte[3:0] == 4'd0) begin
                        s.verdict = ggep_pkg::ST_IDZERO;
                    end else begin
                        s.phase = ggep_pkg::PH_ID;
                    end
                end
                ggep_pkg::PH_ID: begin
                    role = ggep_pkg::ROLE_ID;
                    if (i_byte == 8'd0) begin
                        s.verdict = ggep_pkg::ST_IDNUL;
                    end else begin
                        s.id_left = i_state.id_left - 4'd1;
                        if (i_state.id_left == 4'd1) begin
                            s.phase    = ggep_pkg::PH_LEN;
                            s.len_read = 2'd0;
                            s.len_acc  = '0;
                        end
                    end
                end
                ggep_pkg::PH_LEN: begin
                    role = ggep_pkg::ROLE_LEN;
                    // most significant group first, oldest bits fall off the top
                    s.len_acc = {i_state.len_acc[ggep_pkg::LEN_W-ggep_pkg::LEN_GROUP_W-1:0],
                                 i_byte[ggep_pkg::LEN_GROUP_W-1:0]};
                    if (i_byte[7:6] == ggep_pkg::TAG_LAST) begin
                        hdr = 1'b1;
                        if (s.len_acc == '0) begin
                            pdone   = 1'b1;
                            s.phase = end_phase;
                        end else begin
                            s.pay_left = s.len_acc;
                            s.phase    = ggep_pkg::PH_PAYLOAD;
                        end
                    end else if (i_byte[7:6] == ggep_pkg::TAG_MORE) begin
                        s.len_read = i_state.len_read + 2'd1;
                        if (i_state.len_read == 2'd2) begin
                            s.verdict = ggep_pkg::ST_UNTERM;
                        end
                    end else begin
                        s.verdict = ggep_pkg::ST_TAG;
                    end
                end
                ggep_pkg::PH_PAYLOAD: begin
                    role       = ggep_pkg::ROLE_PAYLOAD;
                    s.pay_left = i_state.pay_left - (ggep_pkg::LEN_W)'(1);
                    if (s.pay_left == '0) begin
                        pdone   = 1'b1;
                        s.phase = end_phase;
                    end
                end
                ggep_pkg::PH_AFTER: begin
                    if (i_byte == ggep_pkg::MAGIC_BYTE) begin
                        role    = ggep_pkg::ROLE_MAGIC;
                        s.phase = ggep_pkg::PH_FLAGS;
                    end else begin
                        s.verdict = ggep_pkg::ST_OK;
                    end
                end
                default: begin
                    if (i_byte == ggep_pkg::MAGIC_BYTE) begin
                        role    = ggep_pkg::ROLE_MAGIC;
                        s.phase = ggep_pkg::PH_FLAGS;
                    end else begin
                        s.verdict = ggep_pkg::ST_MAGIC;
                    end
                end
            endcase
        end

        // end of packet settles a running verdict
        if (i_last && s.verdict == ggep_pkg::ST_RUN) begin
            s.verdict = (s.phase == ggep_pkg::PH_AFTER) ? ggep_pkg::ST_OK
                                                         : ggep_pkg::ST_TRUNC;
        end
        status = s.verdict;
        if (i_last && i_state.bytes_seen < ggep_pkg::MIN_PACKET - 3'd1) begin
            status = ggep_pkg::ST_SHORT;
        end

        o_result.byte_role      = role;
        o_result.echo_byte      = i_byte;
        o_result.block_number   = s.block_cnt;
        o_result.block_flags    = s.flags;
        o_result.id_length      = s.flags[3:0];
        o_result.payload_length = s.len_acc;
        o_result.header_done    = hdr;
        o_result.payload_done   = pdone;
        o_result.status         = status;

        if (i_state.bytes_seen < ggep_pkg::MIN_PACKET) begin
            s.bytes_seen = i_state.bytes_seen + 3'd1;
        end
        o_state = i_last ? ggep_pkg::STATE_RESET : s;
    end

endmodule

FILE: test/tb_ggep_block_parser_top.sv
// self-checking testbench for the ggep extension area parser top level
module tb_ggep_block_parser_top;
    import ggep_pkg::*;

    // one byte of the extension area as it waits to be sent
    typedef struct packed {
        logic [7:0] data;
        logic       packet_end;
    } t_area_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'd0;    // [7:0] data_byte
    logic        i_s_tlast = 1'b0;    // packet_end
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [55:0] o_m_tdata;           // echo, block number, flags, id length, payload length,
                                      // header done, payload done, status, zero pad
    logic [2:0]  o_m_tuser;           // [2:0] byte_role

    ggep_block_parser_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_area_byte  bytes_to_send[$];
    t_result     parse_results_due[$];
    logic [7:0]  pkt[$];
    int unsigned items_queued = 0;
    int unsigned fail_cnt = 0;
    int unsigned snd_idle_pct = 35;
    int unsigned rcv_idle_pct = 50;
    bit          hold_request = 1'b0;
    int unsigned hold_left = 0;

    // parser state as the scoreboard tracks it
    logic [2:0]       trk_phase = PH_MAGIC;
    logic [2:0]       trk_seen = 3'd0;
    logic [7:0]       trk_flags = 8'd0;
    logic [3:0]       trk_id_left = 4'd0;
    logic [1:0]       trk_len_rd = 2'd0;
    logic [LEN_W-1:0] trk_len_acc = '0;
    logic [LEN_W-1:0] trk_pay_left = '0;
    logic [7:0]       trk_blk = 8'd0;
    logic [3:0]       trk_verdict = ST_RUN;

    // advance the tracked parser by one byte and give the beat it must produce
    task automatic parse_ggep_byte(input logic [7:0] b, input logic pend, output t_result r);
        logic [2:0] role;
        logic       hdr;
        logic       pdone;
        logic [3:0] st;
        role = ROLE_IGNORED;
        hdr = 1'b0;
        pdone = 1'b0;
        if (trk_verdict == ST_RUN) begin
            case (trk_phase)
                PH_FLAGS: begin
                    role = ROLE_FLAGS;
                    // the first block of the packet stays at index zero
                    if (trk_seen != 3'd1 && trk_blk != 8'hFF)
                        trk_blk = trk_blk + 8'd1;
                    trk_flags = b;
                    trk_len_acc = '0;
                    trk_pay_left = '0;
                    trk_len_rd = 2'd0;
                    trk_id_left = b[3:0];
                    if (trk_id_left == 4'd0)
                        trk_verdict = ST_IDZERO;
                    else
                        trk_phase = PH_ID;
                end
                PH_ID: begin
                    role = ROLE_ID;
                    if (b == 8'd0) begin
                        trk_verdict = ST_IDNUL;
                    end else begin
                        trk_id_left = trk_id_left - 4'd1;
                        if (trk_id_left == 4'd0) begin
                            trk_phase = PH_LEN;
                            trk_len_rd = 2'd0;
                            trk_len_acc = '0;
                        end
                    end
                end
                PH_LEN: begin
                    role = ROLE_LEN;
                    trk_len_acc = {trk_len_acc[LEN_W-LEN_GROUP_W-1:0], b[5:0]};
                    if (b[7:6] == TAG_LAST) begin
                        hdr = 1'b1;
                        if (trk_len_acc == '0) begin
                            pdone = 1'b1;
                            trk_phase = trk_flags[7] ? PH_AFTER : PH_FLAGS;
                        end else begin
                            trk_pay_left = trk_len_acc;
                            trk_phase = PH_PAYLOAD;
                        end
                    end else if (b[7:6] == TAG_MORE) begin
                        trk_len_rd = trk_len_rd + 2'd1;
                        if (trk_len_rd == 2'd3)
                            trk_verdict = ST_UNTERM;
                    end else begin
                        trk_verdict = ST_TAG;
                    end
                end
                PH_PAYLOAD: begin
                    role = ROLE_PAYLOAD;
                    trk_pay_left = trk_pay_left - (LEN_W)'(1);
                    if (trk_pay_left == '0) begin
                        pdone = 1'b1;
                        trk_phase = trk_flags[7] ? PH_AFTER : PH_FLAGS;
                    end
                end
                PH_AFTER: begin
                    // a magic here opens a new chain, anything else closes parsing
                    if (b == MAGIC_BYTE) begin
                        role = ROLE_MAGIC;
                        trk_phase = PH_FLAGS;
                    end else begin
                        trk_verdict = ST_OK;
                    end
                end
                default: begin
                    if (b == MAGIC_BYTE) begin
                        role = ROLE_MAGIC;
                        trk_phase = PH_FLAGS;
                    end else begin
                        trk_verdict = ST_MAGIC;
                    end
                end
            endcase
        end
        if (pend && trk_verdict == ST_RUN)
            trk_verdict = (trk_phase == PH_AFTER) ? ST_OK : ST_TRUNC;
        st = trk_verdict;
        if (pend && (trk_seen + 3'd1) < MIN_PACKET)
            st = ST_SHORT;
        r.byte_role = role;
        r.echo_byte = b;
        r.block_number = trk_blk;
        r.block_flags = trk_flags;
        r.id_length = trk_flags[3:0];
        r.payload_length = trk_len_acc;
        r.header_done = hdr;
        r.payload_done = pdone;
        r.status = st;
        if (trk_seen < MIN_PACKET)
            trk_seen = trk_seen + 3'd1;
        // packet end puts the whole parser back to its reset state
        if (pend) begin
            trk_phase = PH_MAGIC;
            trk_seen = 3'd0;
            trk_flags = 8'd0;
            trk_id_left = 4'd0;
            trk_len_rd = 2'd0;
            trk_len_acc = '0;
            trk_pay_left = '0;
            trk_blk = 8'd0;
            trk_verdict = ST_RUN;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // queue the assembled packet, marking its final byte
    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++) begin
            bytes_to_send.push_back('{data: pkt[i], packet_end: (i == pkt.size() - 1)});
            items_queued++;
        end
    endtask

    // well-formed chains with random content, then an occasional corruption
    task automatic build_packet();
        int unsigned chains;
        int unsigned blocks;
        int unsigned idl;
        int unsigned plen;
        int unsigned n_grp;
        int unsigned pick;
        int unsigned cut;
        logic [7:0]  tail;
        bit          stop;
        pkt.delete();
        stop = 1'b0;
        pkt.push_back(MAGIC_BYTE);
        chains = ($urandom_range(99) < 30) ? 2 : 1;
        for (int c = 0; c < chains && !stop; c++) begin
            if (c > 0)
                pkt.push_back(MAGIC_BYTE);
            blocks = $urandom_range(1, 3);
            for (int k = 0; k < blocks && !stop; k++) begin
                idl = ($urandom_range(9) == 0) ? $urandom_range(4, 15) : $urandom_range(1, 3);
                pkt.push_back({(k == blocks - 1), 3'($urandom_range(7)), 4'(idl)});
                repeat (idl) pkt.push_back(8'($urandom_range(1, 255)));
                pick = $urandom_range(99);
                if (pick < 70)
                    plen = $urandom_range(5);
                else if (pick < 88)
                    plen = $urandom_range(6, 100);
                else
                    plen = $urandom_range(262143);
                n_grp = (plen < 64) ? 1 : (plen < 4096) ? 2 : 3;
                // leading zero groups are legal and sometimes used
                if (n_grp < 3 && $urandom_range(3) == 0)
                    n_grp = n_grp + $urandom_range(1, 3 - n_grp);
                for (int g = n_grp - 1; g >= 0; g--)
                    pkt.push_back({(g == 0) ? TAG_LAST : TAG_MORE, 6'(plen >> (6 * g))});
                if (plen > 100) begin
                    // long payloads are cut short by the packet end
                    repeat ($urandom_range(3)) pkt.push_back(8'($urandom));
                    stop = 1'b1;
                end else begin
                    repeat (plen) pkt.push_back(8'($urandom));
                end
            end
        end
        if (!stop && $urandom_range(1) == 1) begin
            do tail = 8'($urandom); while (tail == MAGIC_BYTE);
            pkt.push_back(tail);
            repeat ($urandom_range(3)) pkt.push_back(8'($urandom));
        end
        pick = $urandom_range(99);
        if (pick < 12) begin
            pkt[$urandom_range(pkt.size() - 1)] = 8'($urandom);
        end else if (pick < 24) begin
            cut = $urandom_range(1, pkt.size());
            while (pkt.size() > cut) void'(pkt.pop_back());
        end else if (pick < 28) begin
            pkt.delete();
            repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
        end
    endtask

    task automatic wait_until_drained();
        while (bytes_to_send.size() != 0) @(posedge i_clk);
        while (parse_results_due.size() != 0) @(posedge i_clk);
    endtask

    // sender: offers the front byte, predicts each accepted beat
    always @(posedge i_clk) begin : drive_input
        t_result due;
        bit      taken;
        taken = i_rst_n && i_s_tvalid && o_s_tready;
        if (taken) begin
            parse_ggep_byte(i_s_tdata, i_s_tlast, due);
            parse_results_due.push_back(due);
            void'(bytes_to_send.pop_front());
        end
        @(negedge i_clk);
        if (i_s_tvalid && !taken) begin
            // beat still pending, hold it
        end else if (i_rst_n && bytes_to_send.size() != 0
                     && $urandom_range(99) >= snd_idle_pct) begin
            i_s_tvalid = 1'b1;
            i_s_tdata = bytes_to_send[0].data;
            i_s_tlast = bytes_to_send[0].packet_end;
        end else begin
            i_s_tvalid = 1'b0;
        end
    end

    // receiver: random back-pressure plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left = 80;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            i_m_tready = 1'b0;
            hold_left--;
        end else begin
            i_m_tready = ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // compare every output beat with the oldest predicted result
    always @(posedge i_clk) begin : check_output
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (parse_results_due.size() == 0) begin
                $error("output beat with no result due: tdata %h tuser %0d",
                       o_m_tdata, o_m_tuser);
                fail_cnt++;
            end else begin
                want = parse_results_due.pop_front();
                check_field("byte_role", 32'(want.byte_role), 32'(o_m_tuser));
                check_field("echo_byte", 32'(want.echo_byte), 32'(o_m_tdata[7:0]));
                check_field("block_number", 32'(want.block_number), 32'(o_m_tdata[15:8]));
                check_field("block_flags", 32'(want.block_flags), 32'(o_m_tdata[23:16]));
                check_field("id_length", 32'(want.id_length), 32'(o_m_tdata[27:24]));
                check_field("payload_length", 32'(want.payload_length),
                            32'(o_m_tdata[45:28]));
                check_field("header_done", 32'(want.header_done), 32'(o_m_tdata[46]));
                check_field("payload_done", 32'(want.payload_done), 32'(o_m_tdata[47]));
                check_field("status", 32'(want.status), 32'(o_m_tdata[51:48]));
                check_field("tdata_pad", 0, 32'(o_m_tdata[55:52]));
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    initial begin
        wait (i_rst_n);

        // too short, zero length block that ends the chain
        pkt = {MAGIC_BYTE, 8'h81, 8'h41, 8'h40};
        send_packet();
        // bad magic, then a short packet end
        pkt = {8'hFF, 8'h00};
        send_packet();
        // id length zero
        pkt = {MAGIC_BYTE, 8'hF0, 8'h00};
        send_packet();
        // nul inside the id
        pkt = {MAGIC_BYTE, 8'h01, 8'h00};
        send_packet();
        // length byte with both tag bits set
        pkt = {MAGIC_BYTE, 8'h01, 8'h41, 8'hC5};
        send_packet();
        // three length bytes tagged more
        pkt = {MAGIC_BYTE, 8'h01, 8'h41, 8'hBF, 8'hBF, 8'hBF};
        send_packet();
        // payload, last block, second chain, chain closed by a non-magic byte
        pkt = {MAGIC_BYTE, 8'h81, 8'h41, 8'h41, 8'hAA, MAGIC_BYTE, 8'h81, 8'h7F, 8'h40, 8'h55};
        send_packet();

        while (items_queued < 400) begin
            build_packet();
            send_packet();
        end
        wait_until_drained();

        // sender idles more than the receiver, and the receiver stalls for a long stretch
        snd_idle_pct = 50;
        rcv_idle_pct = 35;
        while (items_queued < 780) begin
            build_packet();
            send_packet();
        end
        hold_request = 1'b1;
        wait_until_drained();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        while (items_queued < 860) begin
            build_packet();
            send_packet();
        end
        // enough blocks in one packet to saturate the block index
        pkt.delete();
        pkt.push_back(MAGIC_BYTE);
        for (int k = 0; k < 258; k++) begin
            pkt.push_back((k == 257) ? 8'h81 : 8'h01);
            pkt.push_back(8'h41);
            pkt.push_back(8'h40);
        end
        send_packet();
        wait_until_drained();

        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("ggep_block_parser_top verification clean");
        else
            $display("ggep_block_parser_top verification failed");
        $finish;
    end

    initial begin
        #6000000;
        $display("ggep_block_parser_top verification failed");
        $finish;
    end

endmodule
